>>> rtl/air_pkg.sv
// shared types and constants for the acknowledged item reassembler
package air_pkg;

    localparam int MaxItemBytes = 32;
    localparam int ByteIdxW     = $clog2(MaxItemBytes);
    localparam int LenW         = 6;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 32;

    localparam logic [1:0] OP_ARM   = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_HEAD_FIRST      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEAD_SECOND     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TAIL_VALUE      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DATA_TYPE_BASE  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ACK_TYPE_BASE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_EXPECTED_LENGTH = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_WAIT_LIMIT_MS   = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic idx_clear;
        logic idx_inc;
        logic emit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_result;
        logic complete;
        logic out_free;
        logic last_byte;
    } dp_status_t;

endpackage

>>> rtl/acked_item_reassembler_top.sv
// top level of the acknowledged item reassembler
//
//  port group    dir   handshake              contents
//  s_*           in    s_valid / s_ready      operation and 8 frame bytes
//  m_*           out   m_valid / m_ready      ack, data byte or failure (timeout or bad length) result
//  cfg_*         in    cfg_valid / cfg_ready  register index and write data
//
// a request is captured, then evaluated and the state updated when the result register is free
// a completed item then emits each stored byte, each first read through the registered read of the byte store
// a request is taken while the previous result still waits in the result register
// m_ready low stalls the evaluate step or the byte run until the result register drains
// synchronous active-low reset clears the wait, session and result valid; byte store is not cleared
module acked_item_reassembler_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [7:0]                   s_frame_head0,
    input  logic [7:0]                   s_frame_head1,
    input  logic [7:0]                   s_frame_type,
    input  logic [7:0]                   s_frame_item,
    input  logic [7:0]                   s_frame_seq,
    input  logic [7:0]                   s_frame_payload,
    input  logic [7:0]                   s_frame_check,
    input  logic [7:0]                   s_frame_tail,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_result_kind,
    output logic [7:0]                   m_ack_type,
    output logic [7:0]                   m_ack_item,
    output logic [7:0]                   m_ack_seq,
    output logic [4:0]                   m_data_offset,
    output logic [7:0]                   m_data_byte,
    output logic [7:0]                   m_item_id,
    output logic                         m_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [air_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [air_pkg::CfgDataW-1:0] cfg_data
);

    air_pkg::ctrl_cmd_t  cmd;
    air_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    air_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    air_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_operation     (s_operation),
        .s_frame_head0   (s_frame_head0),
        .s_frame_head1   (s_frame_head1),
        .s_frame_type    (s_frame_type),
        .s_frame_item    (s_frame_item),
        .s_frame_seq     (s_frame_seq),
        .s_frame_payload (s_frame_payload),
        .s_frame_check   (s_frame_check),
        .s_frame_tail    (s_frame_tail),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_ack_type      (m_ack_type),
        .m_ack_item      (m_ack_item),
        .m_ack_seq       (m_ack_seq),
        .m_data_offset   (m_data_offset),
        .m_data_byte     (m_data_byte),
        .m_item_id       (m_item_id),
        .m_last          (m_last)
    );

endmodule

>>> rtl/air_ram.sv
// generic single write port ram with registered read
module air_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/air_ctrl.sv
// controller state machine for the acknowledged item reassembler
module air_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  air_pkg::dp_status_t status,
    output air_pkg::ctrl_cmd_t  cmd
);

    air_pkg::state_t state_reg;
    air_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= air_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            air_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = air_pkg::ST_EVAL;
                end
            end
            air_pkg::ST_EVAL: begin
                if (status.out_free || !status.has_result) begin
                    cmd.commit = 1'b1;
                    if (status.complete) begin
                        cmd.idx_clear = 1'b1;
                        state_next    = air_pkg::ST_READ;
                    end else begin
                        state_next = air_pkg::ST_IDLE;
                    end
                end
            end
            air_pkg::ST_READ: begin
                state_next = air_pkg::ST_EMIT;
            end
            air_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_byte) begin
                        cmd.finish = 1'b1;
                        state_next = air_pkg::ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = air_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = air_pkg::ST_IDLE;
            end
        endcase
    end

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.commit, cmd.emit}))
        else $error("controller issued more than one action");

    a_emit_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == air_pkg::ST_READ |=> state_reg == air_pkg::ST_EMIT)
        else $error("read not followed by emit");

endmodule

>>> rtl/air_datapath.sv
// datapath: config registers, frame checks, session state, byte store, result register
module air_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  air_pkg::ctrl_cmd_t           cmd,
    output air_pkg::dp_status_t          status,
    input  logic                         cfg_valid,
    input  logic [air_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [air_pkg::CfgDataW-1:0] cfg_data,
    input  logic [1:0]                   s_operation,
    input  logic [7:0]                   s_frame_head0,
    input  logic [7:0]                   s_frame_head1,
    input  logic [7:0]                   s_frame_type,
    input  logic [7:0]                   s_frame_item,
    input  logic [7:0]                   s_frame_seq,
    input  logic [7:0]                   s_frame_payload,
    input  logic [7:0]                   s_frame_check,
    input  logic [7:0]                   s_frame_tail,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_result_kind,
    output logic [7:0]                   m_ack_type,
    output logic [7:0]                   m_ack_item,
    output logic [7:0]                   m_ack_seq,
    output logic [4:0]                   m_data_offset,
    output logic [7:0]                   m_data_byte,
    output logic [7:0]                   m_item_id,
    output logic                         m_last
);

    localparam int NB = air_pkg::MaxItemBytes;
    localparam int IW = air_pkg::ByteIdxW;
    localparam int LW = air_pkg::LenW;

    // config registers
    logic [7:0]    head_first_reg, head_second_reg, tail_value_reg;
    logic [7:0]    data_type_base_reg, ack_type_base_reg;
    logic [LW-1:0] expected_length_reg;
    logic [31:0]   wait_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_first_reg      <= 8'd0;
            head_second_reg     <= 8'd0;
            tail_value_reg      <= 8'd0;
            data_type_base_reg  <= 8'd0;
            ack_type_base_reg   <= 8'd0;
            expected_length_reg <= LW'(1);
            wait_limit_reg      <= 32'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                air_pkg::CFG_HEAD_FIRST:      head_first_reg      <= cfg_data[7:0];
                air_pkg::CFG_HEAD_SECOND:     head_second_reg     <= cfg_data[7:0];
                air_pkg::CFG_TAIL_VALUE:      tail_value_reg      <= cfg_data[7:0];
                air_pkg::CFG_DATA_TYPE_BASE:  data_type_base_reg  <= cfg_data[7:0];
                air_pkg::CFG_ACK_TYPE_BASE:   ack_type_base_reg   <= cfg_data[7:0];
                air_pkg::CFG_EXPECTED_LENGTH: expected_length_reg <= cfg_data[LW-1:0];
                air_pkg::CFG_WAIT_LIMIT_MS:   wait_limit_reg      <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // captured request
    logic [1:0] op_reg;
    logic [7:0] head0_reg, head1_reg, type_reg, item_reg, seq_reg;
    logic [7:0] pay_reg, check_reg, tail_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_operation;
            head0_reg <= s_frame_head0;
            head1_reg <= s_frame_head1;
            type_reg  <= s_frame_type;
            item_reg  <= s_frame_item;
            seq_reg   <= s_frame_seq;
            pay_reg   <= s_frame_payload;
            check_reg <= s_frame_check;
            tail_reg  <= s_frame_tail;
        end
    end

    // wait and session state
    logic          armed_reg, armed_next;
    logic          open_reg, open_next;
    logic [7:0]    sess_item_reg, sess_item_next;
    logic [7:0]    sess_seq_reg, sess_seq_next;
    logic [LW-1:0] count_reg, count_next;
    logic [NB-1:0] mask_reg, mask_next;
    logic [31:0]   elapsed_reg, elapsed_next;
    logic [LW-1:0] idx_reg, idx_next;

    // request evaluation
    logic          is_arm, is_tick, is_frame, len_bad;
    logic [31:0]   elapsed_inc;
    logic          tick_live, tick_fire;
    logic [7:0]    sum;
    logic [8:0]    type_end;
    logic          type_ok, frame_ok, in_range, restart, is_new, complete;
    logic [7:0]    off_full;
    logic [IW-1:0] off;
    logic [7:0]    ack_code;
    logic [NB-1:0] mask_base, off_bit;
    logic [LW-1:0] count_new;
    logic          has_result, store_we;
    logic [7:0]    rdata;

    always_comb begin
        is_arm      = (op_reg == air_pkg::OP_ARM);
        is_tick     = (op_reg == air_pkg::OP_TICK);
        is_frame    = (op_reg == air_pkg::OP_FRAME);
        len_bad     = (expected_length_reg == '0) || (expected_length_reg > LW'(NB));
        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
        tick_live   = is_tick && armed_reg && (wait_limit_reg != 32'd0);
        tick_fire   = tick_live && (elapsed_inc >= wait_limit_reg);
        sum         = type_reg + item_reg + seq_reg + pay_reg;
        type_end    = {1'b0, data_type_base_reg} + 9'(NB);
        type_ok     = (type_reg >= data_type_base_reg) && ({1'b0, type_reg} < type_end);
        frame_ok    = is_frame && armed_reg && (head0_reg == head_first_reg)
                      && (head1_reg == head_second_reg) && (tail_reg == tail_value_reg)
                      && (check_reg == sum) && type_ok;
        off_full    = type_reg - data_type_base_reg;
        off         = off_full[IW-1:0];
        ack_code    = ack_type_base_reg + 8'(off);
        in_range    = LW'(off) < expected_length_reg;
        restart     = !open_reg || (item_reg != sess_item_reg) || (seq_reg != sess_seq_reg);
        mask_base   = restart ? '0 : mask_reg;
        off_bit     = NB'(1) << off;
        is_new      = !mask_base[off];
        count_new   = (restart ? '0 : count_reg) + LW'(is_new);
        complete    = frame_ok && in_range && (count_new >= expected_length_reg);
        has_result  = (is_arm && len_bad) || tick_fire || frame_ok;
        store_we    = cmd.commit && frame_ok && in_range && is_new;
    end

    always_comb begin
        armed_next     = armed_reg;
        open_next      = open_reg;
        sess_item_next = sess_item_reg;
        sess_seq_next  = sess_seq_reg;
        count_next     = count_reg;
        mask_next      = mask_reg;
        elapsed_next   = elapsed_reg;
        idx_next       = idx_reg;
        if (cmd.commit) begin
            if (is_arm) begin
                armed_next   = !len_bad;
                open_next    = 1'b0;
                elapsed_next = 32'd0;
                count_next   = '0;
                mask_next    = '0;
            end else if (tick_live) begin
                elapsed_next = elapsed_inc;
                if (tick_fire) begin
                    armed_next = 1'b0;
                end
            end else if (frame_ok && in_range) begin
                open_next      = 1'b1;
                sess_item_next = item_reg;
                sess_seq_next  = seq_reg;
                mask_next      = mask_base | off_bit;
                count_next     = count_new;
            end
        end
        if (cmd.finish) begin
            armed_next = 1'b0;
            open_next  = 1'b0;
        end
        if (cmd.idx_clear) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= 1'b0;
            open_reg      <= 1'b0;
            sess_item_reg <= 8'd0;
            sess_seq_reg  <= 8'd0;
            count_reg     <= '0;
            mask_reg      <= '0;
            elapsed_reg   <= 32'd0;
            idx_reg       <= '0;
        end else begin
            armed_reg     <= armed_next;
            open_reg      <= open_next;
            sess_item_reg <= sess_item_next;
            sess_seq_reg  <= sess_seq_next;
            count_reg     <= count_next;
            mask_reg      <= mask_next;
            elapsed_reg   <= elapsed_next;
            idx_reg       <= idx_next;
        end
    end

    air_ram #(
        .Width (8),
        .Depth (NB)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (off),
        .wdata (pay_reg),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [1:0] kind_reg;
    logic [7:0] ack_type_reg, ack_item_reg, ack_seq_reg;
    logic [4:0] offset_reg;
    logic [7:0] byte_reg, id_reg;
    logic       last_reg;
    logic       out_free, last_byte, load_result;

    assign out_free    = !out_valid_reg || m_ready;
    assign last_byte   = (idx_reg + LW'(1)) == expected_length_reg;
    assign load_result = cmd.commit && has_result;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_result || cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            offset_reg <= 5'd0;
            byte_reg   <= 8'd0;
            id_reg     <= 8'd0;
            if (frame_ok) begin
                kind_reg     <= air_pkg::KIND_ACK;
                ack_type_reg <= ack_code;
                ack_item_reg <= item_reg;
                ack_seq_reg  <= seq_reg;
                last_reg     <= !complete;
            end else begin
                kind_reg     <= air_pkg::KIND_FAIL;
                ack_type_reg <= 8'd0;
                ack_item_reg <= 8'd0;
                ack_seq_reg  <= 8'd0;
                last_reg     <= 1'b1;
            end
        end else if (cmd.emit) begin
            kind_reg     <= air_pkg::KIND_DATA;
            ack_type_reg <= 8'd0;
            ack_item_reg <= 8'd0;
            ack_seq_reg  <= 8'd0;
            offset_reg   <= 5'(idx_reg[IW-1:0]);
            byte_reg     <= mask_reg[idx_reg[IW-1:0]] ? rdata : 8'd0;
            id_reg       <= sess_item_reg;
            last_reg     <= last_byte;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_ack_type    = ack_type_reg;
    assign m_ack_item    = ack_item_reg;
    assign m_ack_seq     = ack_seq_reg;
    assign m_data_offset = offset_reg;
    assign m_data_byte   = byte_reg;
    assign m_item_id     = id_reg;
    assign m_last        = last_reg;

    assign status.has_result = has_result;
    assign status.complete   = complete;
    assign status.out_free   = out_free;
    assign status.last_byte  = last_byte;

    a_count_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) == 32'($countones(mask_reg)))
        else $error("received count out of step with mask");

    a_emit_while_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> armed_reg && open_reg)
        else $error("byte emitted outside an open session");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_result || cmd.emit) |-> out_free)
        else $error("result register overwritten before taken");

endmodule

>>> tb/sv/acked_item_reassembler_top_test.sv
// self-checking testbench for the acknowledged item reassembler top level
module acked_item_reassembler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 4000;
    localparam int DrainCycles   = 12;
    localparam int RandomItems   = 100;

    // operation code with no meaning to the block
    localparam logic [1:0] OpUnused = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] head0;
        logic [7:0] head1;
        logic [7:0] ftype;
        logic [7:0] item;
        logic [7:0] seq;
        logic [7:0] payload;
        logic [7:0] check;
        logic [7:0] tail;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ack_type;
        logic [7:0] ack_item;
        logic [7:0] ack_seq;
        logic [4:0] data_offset;
        logic [7:0] data_byte;
        logic [7:0] item_id;
        logic       last;
    } res_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [1:0]                   s_operation;
    logic [7:0]                   s_frame_head0;
    logic [7:0]                   s_frame_head1;
    logic [7:0]                   s_frame_type;
    logic [7:0]                   s_frame_item;
    logic [7:0]                   s_frame_seq;
    logic [7:0]                   s_frame_payload;
    logic [7:0]                   s_frame_check;
    logic [7:0]                   s_frame_tail;
    logic                         m_valid;
    logic                         m_ready;
    logic [1:0]                   m_result_kind;
    logic [7:0]                   m_ack_type;
    logic [7:0]                   m_ack_item;
    logic [7:0]                   m_ack_seq;
    logic [4:0]                   m_data_offset;
    logic [7:0]                   m_data_byte;
    logic [7:0]                   m_item_id;
    logic                         m_last;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [air_pkg::CfgIdxW-1:0]  cfg_index;
    logic [air_pkg::CfgDataW-1:0] cfg_data;

    // register mirror
    logic [7:0]  head_first_reg;
    logic [7:0]  head_second_reg;
    logic [7:0]  tail_reg;
    logic [7:0]  data_base_reg;
    logic [7:0]  ack_base_reg;
    logic [5:0]  length_reg;
    logic [31:0] wait_limit_reg;

    // receiver state mirror
    logic        armed;
    logic        session_open;
    logic [7:0]  session_item;
    logic [7:0]  session_seq;
    logic [5:0]  received_count;
    logic [31:0] received_mask;
    logic [7:0]  byte_store [air_pkg::MaxItemBytes];
    logic [31:0] elapsed_ms;
    logic        took_effect;

    res_t pending_results [$];
    int   fail_count;
    int   idle_cycles;
    bit   burst_mode;

    acked_item_reassembler_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_frame_head0   (s_frame_head0),
        .s_frame_head1   (s_frame_head1),
        .s_frame_type    (s_frame_type),
        .s_frame_item    (s_frame_item),
        .s_frame_seq     (s_frame_seq),
        .s_frame_payload (s_frame_payload),
        .s_frame_check   (s_frame_check),
        .s_frame_tail    (s_frame_tail),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_ack_type      (m_ack_type),
        .m_ack_item      (m_ack_item),
        .m_ack_seq       (m_ack_seq),
        .m_data_offset   (m_data_offset),
        .m_data_byte     (m_data_byte),
        .m_item_id       (m_item_id),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic string fmt_result(input res_t r);
        return $sformatf("kind=%0d ack=%02h/%02h/%02h off=%0d byte=%02h id=%02h last=%0d",
                         r.kind, r.ack_type, r.ack_item, r.ack_seq, r.data_offset,
                         r.data_byte, r.item_id, r.last);
    endfunction

    task automatic note_mismatch(input string msg);
        if (fail_count < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic clear_session();
        received_count = '0;
        received_mask  = '0;
        for (int i = 0; i < air_pkg::MaxItemBytes; i++) begin
            byte_store[i] = 8'h00;
        end
    endtask

    task automatic predict_reassembly(input req_t r);
        res_t        e;
        res_t        d;
        int unsigned off;
        logic        frame_ok;
        e = '0;
        took_effect = 1'b0;
        case (r.op)
            air_pkg::OP_ARM: begin
                took_effect  = 1'b1;
                session_open = 1'b0;
                elapsed_ms   = '0;
                clear_session();
                if (length_reg == 0 || length_reg > air_pkg::MaxItemBytes) begin
                    armed  = 1'b0;
                    e.kind = air_pkg::KIND_FAIL;
                    e.last = 1'b1;
                    pending_results.push_back(e);
                end else begin
                    armed = 1'b1;
                end
            end
            air_pkg::OP_TICK: begin
                if (armed && wait_limit_reg != 0) begin
                    took_effect = 1'b1;
                    if (elapsed_ms != 32'hFFFF_FFFF) elapsed_ms++;
                    if (elapsed_ms >= wait_limit_reg) begin
                        armed  = 1'b0;
                        e.kind = air_pkg::KIND_FAIL;
                        e.last = 1'b1;
                        pending_results.push_back(e);
                    end
                end
            end
            air_pkg::OP_FRAME: begin
                frame_ok = r.head0 == head_first_reg && r.head1 == head_second_reg
                        && r.tail == tail_reg
                        && r.check == 8'(r.ftype + r.item + r.seq + r.payload)
                        && int'(r.ftype) >= int'(data_base_reg)
                        && int'(r.ftype) < int'(data_base_reg) + air_pkg::MaxItemBytes;
                if (armed && frame_ok) begin
                    took_effect = 1'b1;
                    off = int'(r.ftype) - int'(data_base_reg);
                    e.kind     = air_pkg::KIND_ACK;
                    e.ack_type = ack_base_reg + 8'(off[5:0]);
                    e.ack_item = r.item;
                    e.ack_seq  = r.seq;
                    if (off >= length_reg) begin
                        e.last = 1'b1;
                        pending_results.push_back(e);
                    end else begin
                        if (!session_open || r.item != session_item || r.seq != session_seq) begin
                            session_open = 1'b1;
                            session_item = r.item;
                            session_seq  = r.seq;
                            clear_session();
                        end
                        if (!received_mask[off]) begin
                            byte_store[off]    = r.payload;
                            received_mask[off] = 1'b1;
                            received_count     = received_count + 6'd1;
                        end
                        if (received_count < length_reg) begin
                            e.last = 1'b1;
                            pending_results.push_back(e);
                        end else begin
                            pending_results.push_back(e);
                            for (int k = 0; k < length_reg && k < air_pkg::MaxItemBytes;
                                 k++) begin
                                d = '0;
                                d.kind        = air_pkg::KIND_DATA;
                                d.data_offset = k[4:0];
                                d.data_byte   = byte_store[k];
                                d.item_id     = session_item;
                                d.last        = (k == length_reg - 1);
                                pending_results.push_back(d);
                            end
                            armed        = 1'b0;
                            session_open = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic req_t make_frame(input logic [7:0] ftype, item, seq, payload);
        req_t r;
        r.op      = air_pkg::OP_FRAME;
        r.head0   = head_first_reg;
        r.head1   = head_second_reg;
        r.ftype   = ftype;
        r.item    = item;
        r.seq     = seq;
        r.payload = payload;
        r.check   = ftype + item + seq + payload;
        r.tail    = tail_reg;
        return r;
    endfunction

    function automatic req_t make_cmd(input logic [1:0] op);
        req_t r;
        r    = make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        r.op = op;
        return r;
    endfunction

    function automatic req_t make_noise();
        req_t r;
        r = make_frame(data_base_reg + 8'($urandom_range(0, 31)), 8'($urandom),
                       8'($urandom), 8'($urandom));
        case ($urandom_range(0, 6))
            0: r.head0 = r.head0 ^ 8'($urandom_range(1, 255));
            1: r.head1 = r.head1 ^ 8'($urandom_range(1, 255));
            2: r.tail  = r.tail ^ 8'($urandom_range(1, 255));
            3: r.check = r.check ^ 8'($urandom_range(1, 255));
            4: begin
                if (data_base_reg > 0) begin
                    r = make_frame(8'($urandom_range(0, data_base_reg - 1)), r.item, r.seq,
                                   r.payload);
                end else begin
                    r = make_frame(8'($urandom_range(32, 255)), r.item, r.seq, r.payload);
                end
            end
            5: r = req_t'({2'($urandom), $urandom, $urandom});
            default: r.op = OpUnused;
        endcase
        return r;
    endfunction

    task automatic send_item(input req_t r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation     <= r.op;
        s_frame_head0   <= r.head0;
        s_frame_head1   <= r.head1;
        s_frame_type    <= r.ftype;
        s_frame_item    <= r.item;
        s_frame_seq     <= r.seq;
        s_frame_payload <= r.payload;
        s_frame_check   <= r.check;
        s_frame_tail    <= r.tail;
        s_valid         <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_reassembly(r);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_results();
        drop_valid();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [air_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            air_pkg::CFG_HEAD_FIRST:      head_first_reg  = data[7:0];
            air_pkg::CFG_HEAD_SECOND:     head_second_reg = data[7:0];
            air_pkg::CFG_TAIL_VALUE:      tail_reg        = data[7:0];
            air_pkg::CFG_DATA_TYPE_BASE:  data_base_reg   = data[7:0];
            air_pkg::CFG_ACK_TYPE_BASE:   ack_base_reg    = data[7:0];
            air_pkg::CFG_EXPECTED_LENGTH: length_reg      = data[5:0];
            air_pkg::CFG_WAIT_LIMIT_MS:   wait_limit_reg  = data;
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] h0, h1, tl, dbase, abase,
                             input logic [5:0] len, input logic [31:0] limit);
        wait_idle();
        write_reg(air_pkg::CFG_HEAD_FIRST, 32'(h0));
        write_reg(air_pkg::CFG_HEAD_SECOND, 32'(h1));
        write_reg(air_pkg::CFG_TAIL_VALUE, 32'(tl));
        write_reg(air_pkg::CFG_DATA_TYPE_BASE, 32'(dbase));
        write_reg(air_pkg::CFG_ACK_TYPE_BASE, 32'(abase));
        write_reg(air_pkg::CFG_EXPECTED_LENGTH, 32'(len));
        write_reg(air_pkg::CFG_WAIT_LIMIT_MS, limit);
    endtask

    task automatic test_reset_defaults();
        send_item(make_frame(8'h00, 8'h00, 8'h00, 8'h00));
        send_item(make_cmd(air_pkg::OP_ARM));
        send_item(make_cmd(air_pkg::OP_TICK));
        send_item(make_cmd(OpUnused));
        send_item(make_frame(8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_frame_checks();
        req_t r;
        configure(8'hFF, 8'h00, 8'hFF, 8'hF0, 8'hFF, 6'd4, 32'd0);
        send_item(make_cmd(air_pkg::OP_ARM));
        r = make_frame(8'hF1, 8'hFF, 8'hFF, 8'hFF);
        r.head0 = ~r.head0;
        send_item(r);
        r = make_frame(8'hF1, 8'hFF, 8'hFF, 8'hFF);
        r.head1 = ~r.head1;
        send_item(r);
        r = make_frame(8'hF1, 8'hFF, 8'hFF, 8'hFF);
        r.tail = ~r.tail;
        send_item(r);
        r = make_frame(8'hF1, 8'hFF, 8'hFF, 8'hFF);
        r.check = r.check + 8'd1;
        send_item(r);
        send_item(make_frame(8'hEF, 8'hFF, 8'hFF, 8'hFF));
        // offset past the length, ack type wraps
        send_item(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_frame(8'hF1, 8'hFF, 8'hFF, 8'hFF));
        // duplicate byte keeps the first value
        send_item(make_frame(8'hF1, 8'hFF, 8'hFF, 8'h00));
        send_item(make_frame(8'hF0, 8'hFF, 8'hFF, 8'h5A));
        // new sequence restarts the session
        send_item(make_frame(8'hF2, 8'hFF, 8'h00, 8'h11));
        send_item(make_frame(8'hF0, 8'hFF, 8'h00, 8'h00));
        send_item(make_frame(8'hF1, 8'hFF, 8'h00, 8'h80));
        send_item(make_frame(8'hF3, 8'hFF, 8'h00, 8'h7F));
    endtask

    task automatic test_timeout();
        configure(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 6'd2, 32'd3);
        send_item(make_cmd(air_pkg::OP_ARM));
        send_item(make_cmd(air_pkg::OP_TICK));
        wait_results();
        send_item(make_cmd(air_pkg::OP_TICK));
        send_item(make_cmd(air_pkg::OP_TICK));
        send_item(make_frame(8'h00, 8'h01, 8'h02, 8'h03));
    endtask

    task automatic test_bad_length();
        wait_idle();
        write_reg(air_pkg::CFG_EXPECTED_LENGTH, 32'd0);
        send_item(make_cmd(air_pkg::OP_ARM));
        wait_idle();
        write_reg(air_pkg::CFG_EXPECTED_LENGTH, 32'd63);
        send_item(make_cmd(air_pkg::OP_ARM));
    endtask

    task automatic test_random_sessions();
        int          order [air_pkg::MaxItemBytes];
        int          pos;
        int          roll;
        int          tmp;
        int          j;
        int          off;
        int          budget;
        int          phase_items;
        int          total_items;
        int          phase;
        logic [5:0]  len;
        logic [31:0] limit;
        logic [7:0]  dbase;
        logic [7:0]  item_tag;
        logic [7:0]  cur_seq;
        bit          fresh;
        total_items = 0;
        phase = 0;
        while (total_items < RandomItems) begin
            len = (phase == 1) ? 6'd32 : (phase == 2) ? 6'd1 : 6'($urandom_range(1, 6));
            limit = (phase == 3) ? 32'hFFFF_FFFF
                  : (phase % 3 == 0) ? 32'($urandom_range(4, 30)) : 32'd0;
            case ($urandom_range(0, 3))
                0:       dbase = 8'h00;
                1:       dbase = 8'(256 - len);
                default: dbase = 8'($urandom_range(0, 256 - len));
            endcase
            configure(8'($urandom), 8'($urandom), 8'($urandom), dbase, 8'($urandom), len, limit);
            burst_mode = (phase % 4 == 2);
            budget = (len == 32) ? 45 : 20;
            phase_items = 0;
            fresh = 1'b1;
            pos = 0;
            while (phase_items < budget) begin
                if (!armed || fresh) begin
                    send_item(make_cmd(air_pkg::OP_ARM));
                    item_tag = 8'($urandom);
                    cur_seq  = 8'($urandom);
                    fresh = 1'b0;
                    pos = 0;
                    for (int i = 0; i < air_pkg::MaxItemBytes; i++) order[i] = i;
                    for (int i = int'(len) - 1; i > 0; i--) begin
                        j = $urandom_range(0, i);
                        tmp = order[i];
                        order[i] = order[j];
                        order[j] = tmp;
                    end
                end else begin
                    roll = $urandom_range(0, 99);
                    if ($urandom_range(0, 11) == 0) wait_results();
                    if (roll < 65 && pos < len) begin
                        send_item(make_frame(dbase + 8'(order[pos]), item_tag, cur_seq,
                                             8'($urandom)));
                        pos++;
                    end else if (roll < 72 && pos > 0) begin
                        send_item(make_frame(dbase + 8'(order[$urandom_range(0, pos - 1)]),
                                             item_tag, cur_seq, 8'($urandom)));
                    end else if (roll < 77 && len < 32 && int'(dbase) + int'(len) <= 255) begin
                        off = $urandom_range(len, (int'(dbase) + 31 > 255) ?
                                             255 - int'(dbase) : 31);
                        send_item(make_frame(dbase + 8'(off), item_tag, cur_seq,
                                             8'($urandom)));
                    end else if (roll < 87) begin
                        send_item(make_noise());
                    end else if (roll < 94) begin
                        send_item(make_cmd(air_pkg::OP_TICK));
                    end else if (roll < 97) begin
                        fresh = 1'b1;
                    end else begin
                        cur_seq = cur_seq + 8'($urandom_range(1, 255));
                        pos = 1;
                        send_item(make_frame(dbase + 8'(order[0]), item_tag, cur_seq,
                                             8'($urandom)));
                    end
                end
                if (took_effect) begin
                    phase_items++;
                    total_items++;
                end
            end
            phase++;
        end
        burst_mode = 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        res_t  act;
        res_t  exp_r;
        string diff;
        if (aresetn && m_valid && m_ready) begin
            act = '{m_result_kind, m_ack_type, m_ack_item, m_ack_seq, m_data_offset,
                    m_data_byte, m_item_id, m_last};
            if (pending_results.size() == 0) begin
                note_mismatch({"unexpected result: ", fmt_result(act)});
            end else begin
                exp_r = pending_results.pop_front();
                diff = "";
                if (act.kind !== exp_r.kind) diff = {diff, " kind"};
                if (act.ack_type !== exp_r.ack_type) diff = {diff, " ack_type"};
                if (act.ack_item !== exp_r.ack_item) diff = {diff, " ack_item"};
                if (act.ack_seq !== exp_r.ack_seq) diff = {diff, " ack_seq"};
                if (act.data_offset !== exp_r.data_offset) diff = {diff, " data_offset"};
                if (act.data_byte !== exp_r.data_byte) diff = {diff, " data_byte"};
                if (act.item_id !== exp_r.item_id) diff = {diff, " item_id"};
                if (act.last !== exp_r.last) diff = {diff, " last"};
                if (diff != "") begin
                    note_mismatch({"mismatch on", diff, ": expected ", fmt_result(exp_r),
                                   ", got ", fmt_result(act)});
                end
            end
        end
    end

    // result channel back-pressure
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = burst_mode ? 0 : $urandom_range(0, 9);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_operation     = air_pkg::OP_ARM;
        s_frame_head0   = 8'h00;
        s_frame_head1   = 8'h00;
        s_frame_type    = 8'h00;
        s_frame_item    = 8'h00;
        s_frame_seq     = 8'h00;
        s_frame_payload = 8'h00;
        s_frame_check   = 8'h00;
        s_frame_tail    = 8'h00;
        cfg_valid       = 1'b0;
        cfg_index       = air_pkg::CFG_HEAD_FIRST;
        cfg_data        = '0;
        fail_count      = 0;
        burst_mode      = 1'b0;
        head_first_reg  = 8'h00;
        head_second_reg = 8'h00;
        tail_reg        = 8'h00;
        data_base_reg   = 8'h00;
        ack_base_reg    = 8'h00;
        length_reg      = 6'd1;
        wait_limit_reg  = 32'd0;
        armed           = 1'b0;
        session_open    = 1'b0;
        session_item    = 8'h00;
        session_seq     = 8'h00;
        elapsed_ms      = 32'd0;
        took_effect     = 1'b0;
        clear_session();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_frame_checks();
        test_timeout();
        test_bad_length();
        test_random_sessions();

        wait_idle();
        repeat (DrainCycles) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/air_pkg.sv
rtl/air_ram.sv
rtl/air_ctrl.sv
rtl/air_datapath.sv
rtl/acked_item_reassembler_top.sv
tb/sv/acked_item_reassembler_top_test.sv
